@@ hw/rtl/rucm_pkg.sv @@
// Shared types and constants for the radial undistortion coordinate map.
// No dependencies; every other file of the block imports this package.
package rucm_pkg;

  // field widths
  localparam int CW    = 10;  // pixel coordinate
  localparam int KW    = 48;  // distortion coefficient
  localparam int AW    = 31;  // vertical aspect, Q30
  localparam int DIMW  = 11;  // source dimension
  localparam int CFGIW = 3;   // register index

  // internal fixed-point widths
  localparam int FB    = 30;  // fraction bits
  localparam int R2W   = 54;  // r^2, Q30
  localparam int R4W   = 62;  // r^4, Q16
  localparam int T1W   = 41;  // |k*r2| >> 60
  localparam int T2W   = 44;  // |k*r4| >> 66
  localparam int NW    = 46;  // numerator / denominator, signed Q30
  localparam int UW    = 45;  // magnitude of NW
  localparam int SATW  = 12;  // factor limit is 2^SATW
  localparam int QFW   = 42;  // quotient bits produced by the divider
  localparam int QW    = 43;  // factor magnitude incl. saturated value
  localparam int YMW   = 41;  // |y1|, Q30
  localparam int RW    = 27;  // rounded offset, signed

  // parameter defaults
  localparam int OUT_WIDTH_DEF      = 938;
  localparam int OUT_HEIGHT_DEF     = 606;
  localparam int MAX_SOURCE_DIM_DEF = 1024;

  typedef enum logic [CFGIW-1:0] {
    CFG_K1,
    CFG_K2,
    CFG_K3,
    CFG_K4,
    CFG_ALPHA,
    CFG_ROWS,
    CFG_COLS
  } cfg_idx_e;

  typedef struct packed {
    logic signed [KW-1:0] k1;
    logic signed [KW-1:0] k2;
    logic signed [KW-1:0] k3;
    logic signed [KW-1:0] k4;
  } coef_t;

  // per-item data that rides alongside the factor computation
  typedef struct packed {
    logic           x_neg;
    logic [CW-1:0]  ax;
    logic           y_neg;
    logic [YMW-1:0] y_mag;
  } side_t;

  // one divider stage
  typedef struct packed {
    logic [UW-1:0]   rem;
    logic [UW-1:0]   ud;
    logic [QFW-1:0]  q;
    logic [SATW-1:0] lo;
    logic            sat;
    logic            zero;
    logic            qneg;
    side_t           side;
  } div_t;

  function automatic logic [KW-1:0] kmag(input logic signed [KW-1:0] k);
    return k[KW-1] ? KW'(-k) : KW'(k);
  endfunction

endpackage

@@ hw/rtl/rucm_if.sv @@
// Valid/ready channel interfaces for coordinate requests and results.
// Depends on rucm_pkg for field widths.
interface rucm_in_if;
  import rucm_pkg::*;
  logic          valid;
  logic          ready;
  logic [CW-1:0] out_row;
  logic [CW-1:0] out_col;
  modport source (output valid, output out_row, output out_col, input ready);
  modport sink (input valid, input out_row, input out_col, output ready);
endinterface

interface rucm_out_if;
  import rucm_pkg::*;
  logic          valid;
  logic          ready;
  logic [CW-1:0] src_row;
  logic [CW-1:0] src_col;
  logic          in_range;
  modport source (output valid, output src_row, output src_col, output in_range, input ready);
  modport sink (input valid, input src_row, input src_col, input in_range, output ready);
endinterface

@@ hw/rtl/rucm_radius.sv @@
// Centering and r^2: three pipeline stages.
// Depends on rucm_pkg.
module rucm_radius #(
  parameter int OUT_WIDTH  = rucm_pkg::OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT = rucm_pkg::OUT_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rucm_pkg::CW-1:0]    out_row_i,
  input  logic [rucm_pkg::CW-1:0]    out_col_i,
  input  logic [rucm_pkg::AW-1:0]    alpha_i,
  output logic                       valid_o,
  output logic [rucm_pkg::R2W-1:0]   r2_o,
  output rucm_pkg::side_t            side_o
);
  import rucm_pkg::*;

  localparam logic signed [CW+1:0] XC = (CW+2)'(OUT_WIDTH / 2);
  localparam logic signed [CW+1:0] YC = (CW+2)'(OUT_HEIGHT / 2);

  logic signed [CW+1:0] xs, ds;
  logic [CW-1:0]        ax, ad;
  side_t                side_d;

  assign xs = $signed({2'b00, out_col_i}) - XC;
  assign ds = YC - $signed({2'b00, out_row_i});
  assign ax = xs[CW+1] ? CW'(-xs) : CW'(xs);
  assign ad = ds[CW+1] ? CW'(-ds) : CW'(ds);

  always_comb begin
    side_d.x_neg = xs[CW+1];
    side_d.ax    = ax;
    side_d.y_neg = ds[CW+1];
    side_d.y_mag = {{(YMW-CW){1'b0}}, ad} * {{(YMW-AW){1'b0}}, alpha_i};
  end

  logic          v1_q, v2_q, v3_q;
  side_t         side1_q, side2_q, side3_q;
  logic [2*CW-1:0] d2_q, ax2_q, ax2b_q;
  logic [2*AW-1:0] a2_q;
  logic [2*CW+32-1:0] mhi_q;
  logic [2*CW+FB-1:0] mlo_q;
  logic [R2W-1:0]     r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: squares of the integer offsets, alpha^2, |y1|
      side1_q <= side_d;
      d2_q    <= {{CW{1'b0}}, ad} * {{CW{1'b0}}, ad};
      ax2_q   <= {{CW{1'b0}}, ax} * {{CW{1'b0}}, ax};
      a2_q    <= {{AW{1'b0}}, alpha_i} * {{AW{1'b0}}, alpha_i};
      // stage 2: d^2 * alpha^2 in two halves
      side2_q <= side1_q;
      ax2b_q  <= ax2_q;
      mhi_q   <= (2*CW+32)'(d2_q) * (2*CW+32)'(a2_q[2*AW-1:FB]);
      mlo_q   <= (2*CW+FB)'(d2_q) * (2*CW+FB)'(a2_q[FB-1:0]);
      // stage 3: r^2 in Q30, y part rounded down
      side3_q <= side2_q;
      r2_q    <= R2W'({ax2b_q, {FB{1'b0}}}) + R2W'(mhi_q)
               + R2W'(mlo_q[2*CW+FB-1:FB]);
    end
  end

  assign valid_o = v3_q;
  assign r2_o    = r2_q;
  assign side_o  = side3_q;

endmodule

@@ hw/rtl/rucm_poly.sv @@
// Numerator and denominator polynomials: r^4 and the four coefficient
// products, split into partial products. Five stages. Depends on rucm_pkg.
module rucm_poly (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [rucm_pkg::R2W-1:0]       r2_i,
  input  rucm_pkg::side_t                side_i,
  input  rucm_pkg::coef_t                coef_i,
  output logic                           valid_o,
  output logic signed [rucm_pkg::NW-1:0] num_o,
  output logic signed [rucm_pkg::NW-1:0] den_o,
  output rucm_pkg::side_t                side_o
);
  import rucm_pkg::*;

  localparam int HW  = R2W / 2;     // r2 half
  localparam int KH  = KW / 2;      // coefficient half
  localparam int QH  = R4W / 2;     // r4 half
  localparam int P1W = KH + HW;
  localparam int P3W = KH + QH;
  localparam int S1W = 2 * (KW + HW);
  localparam int S3W = 2 * (KW + QH) + 1;

  localparam logic signed [NW-1:0] ONE_Q = NW'(1) <<< FB;

  function automatic logic signed [NW-1:0] signed_term(input logic neg,
                                                       input logic [T2W-1:0] m);
    return neg ? -NW'(m) : NW'(m);
  endfunction

  logic [KW-1:0] m1, m2, m3, m4;
  assign m1 = kmag(coef_i.k1);
  assign m2 = kmag(coef_i.k2);
  assign m3 = kmag(coef_i.k3);
  assign m4 = kmag(coef_i.k4);

  logic [4:0] v_q;
  side_t      side_q [5];

  logic [2*HW-1:0] sq_q [3];
  logic [P1W-1:0]  pa_q [4];
  logic [P1W-1:0]  pc_q [4];
  logic [R4W-1:0]  r4_q;
  logic [T1W-1:0]  t1_q, t3_q, t1b_q, t3b_q, t1c_q, t3c_q;
  logic [P3W-1:0]  pb_q [4];
  logic [P3W-1:0]  pd_q [4];
  logic [T2W-1:0]  t2_q, t4_q;
  logic signed [NW-1:0] num_q, den_q;

  logic [HW-1:0]    rh, rl;
  logic [QH-1:0]    qh, ql;
  logic [4*HW-1:0]  sqs;
  logic [S1W-1:0]   s1, s3;
  logic [S3W-1:0]   s2, s4;

  assign rh = r2_i[R2W-1:HW];
  assign rl = r2_i[HW-1:0];
  assign qh = r4_q[R4W-1:QH];
  assign ql = r4_q[QH-1:0];

  assign sqs = ((4*HW)'(sq_q[0]) << (2*HW)) + ((4*HW)'(sq_q[1]) << (HW+1))
             + (4*HW)'(sq_q[2]);
  assign s1 = (S1W'(pa_q[0]) << (KH+HW)) + (S1W'(pa_q[1]) << KH)
            + (S1W'(pa_q[2]) << HW) + S1W'(pa_q[3]);
  assign s3 = (S1W'(pc_q[0]) << (KH+HW)) + (S1W'(pc_q[1]) << KH)
            + (S1W'(pc_q[2]) << HW) + S1W'(pc_q[3]);
  assign s2 = (S3W'(pb_q[0]) << (KH+QH)) + (S3W'(pb_q[1]) << KH)
            + (S3W'(pb_q[2]) << QH) + S3W'(pb_q[3]);
  assign s4 = (S3W'(pd_q[0]) << (KH+QH)) + (S3W'(pd_q[1]) << KH)
            + (S3W'(pd_q[2]) << QH) + S3W'(pd_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // P1: r2^2 partials, k1*r2 and k3*r2 partials
      side_q[0] <= side_i;
      sq_q[0]   <= (2*HW)'(rh) * (2*HW)'(rh);
      sq_q[1]   <= (2*HW)'(rh) * (2*HW)'(rl);
      sq_q[2]   <= (2*HW)'(rl) * (2*HW)'(rl);
      pa_q[0]   <= P1W'(m1[KW-1:KH]) * P1W'(rh);
      pa_q[1]   <= P1W'(m1[KW-1:KH]) * P1W'(rl);
      pa_q[2]   <= P1W'(m1[KH-1:0])  * P1W'(rh);
      pa_q[3]   <= P1W'(m1[KH-1:0])  * P1W'(rl);
      pc_q[0]   <= P1W'(m3[KW-1:KH]) * P1W'(rh);
      pc_q[1]   <= P1W'(m3[KW-1:KH]) * P1W'(rl);
      pc_q[2]   <= P1W'(m3[KH-1:0])  * P1W'(rh);
      pc_q[3]   <= P1W'(m3[KH-1:0])  * P1W'(rl);
      // P2: r4 in Q16, r2 terms truncated to Q30
      side_q[1] <= side_q[0];
      r4_q      <= sqs[R4W+43:44];
      t1_q      <= s1[T1W+59:60];
      t3_q      <= s3[T1W+59:60];
      // P3: k2*r4 and k4*r4 partials
      side_q[2] <= side_q[1];
      t1b_q     <= t1_q;
      t3b_q     <= t3_q;
      pb_q[0]   <= P3W'(m2[KW-1:KH]) * P3W'(qh);
      pb_q[1]   <= P3W'(m2[KW-1:KH]) * P3W'(ql);
      pb_q[2]   <= P3W'(m2[KH-1:0])  * P3W'(qh);
      pb_q[3]   <= P3W'(m2[KH-1:0])  * P3W'(ql);
      pd_q[0]   <= P3W'(m4[KW-1:KH]) * P3W'(qh);
      pd_q[1]   <= P3W'(m4[KW-1:KH]) * P3W'(ql);
      pd_q[2]   <= P3W'(m4[KH-1:0])  * P3W'(qh);
      pd_q[3]   <= P3W'(m4[KH-1:0])  * P3W'(ql);
      // P4: r4 terms truncated to Q30, r2 terms carried along
      side_q[3] <= side_q[2];
      t1c_q     <= t1b_q;
      t3c_q     <= t3b_q;
      t2_q      <= s2[T2W+65:66];
      t4_q      <= s4[T2W+65:66];
      // P5: 1 + terms
      side_q[4] <= side_q[3];
      num_q     <= ONE_Q + signed_term(coef_i.k1[KW-1], T2W'(t1c_q))
                 + signed_term(coef_i.k2[KW-1], t2_q);
      den_q     <= ONE_Q + signed_term(coef_i.k3[KW-1], T2W'(t3c_q))
                 + signed_term(coef_i.k4[KW-1], t4_q);
    end
  end

  assign valid_o = v_q[4];
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q[4];

endmodule

@@ hw/rtl/rucm_div.sv @@
// Pipelined restoring divider for the factor num/den in Q30, one quotient
// bit per stage, with saturation at 2^12. Depends on rucm_pkg.
module rucm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [rucm_pkg::NW-1:0] num_i,
  input  logic signed [rucm_pkg::NW-1:0] den_i,
  input  rucm_pkg::side_t                side_i,
  output logic                           valid_o,
  output logic [rucm_pkg::QW-1:0]        qmag_o,
  output logic                           qneg_o,
  output logic                           zero_o,
  output rucm_pkg::side_t                side_o
);
  import rucm_pkg::*;

  logic [UW-1:0] un, ud;
  div_t          st_d;

  assign un = num_i[NW-1] ? UW'(-num_i) : UW'(num_i);
  assign ud = den_i[NW-1] ? UW'(-den_i) : UW'(den_i);

  always_comb begin
    st_d.rem  = un >> SATW;
    st_d.ud   = ud;
    st_d.q    = '0;
    st_d.lo   = un[SATW-1:0];
    st_d.sat  = {{SATW{1'b0}}, un} >= {ud, {SATW{1'b0}}};
    st_d.zero = (den_i == '0);
    st_d.qneg = num_i[NW-1] ^ den_i[NW-1];
    st_d.side = side_i;
  end

  logic vld_q [QFW+1];
  div_t st_q  [QFW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st_d;
    end
  end

  for (genvar g = 0; g < QFW; g++) begin : g_step
    logic [UW:0] t;
    logic        ge;
    div_t        nxt;

    // next dividend bit comes from the low integer bits, then zeros
    assign t  = {st_q[g].rem, st_q[g].lo[SATW-1]};
    assign ge = t >= {1'b0, st_q[g].ud};

    always_comb begin
      nxt     = st_q[g];
      nxt.rem = ge ? UW'(t - {1'b0, st_q[g].ud}) : UW'(t);
      nxt.q   = {st_q[g].q[QFW-2:0], ge};
      nxt.lo  = st_q[g].lo << 1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g+1] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[QFW];
  assign qmag_o  = st_q[QFW].sat ? (QW'(1) << QFW) : QW'(st_q[QFW].q);
  assign qneg_o  = st_q[QFW].qneg;
  assign zero_o  = st_q[QFW].zero;
  assign side_o  = st_q[QFW].side;

endmodule

@@ hw/rtl/rucm_map.sv @@
// Scales the offsets by the factor, rounds, and maps into the source frame.
// Two stages plus the range check in front of the output register.
// Depends on rucm_pkg.
module rucm_map #(
  parameter int MAX_SOURCE_DIM = rucm_pkg::MAX_SOURCE_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rucm_pkg::QW-1:0]     qmag_i,
  input  logic                        qneg_i,
  input  logic                        zero_i,
  input  rucm_pkg::side_t             side_i,
  input  logic [rucm_pkg::DIMW-1:0]   rows_i,
  input  logic [rucm_pkg::DIMW-1:0]   cols_i,
  output logic                        valid_o,
  output logic [rucm_pkg::CW-1:0]     src_row_o,
  output logic [rucm_pkg::CW-1:0]     src_col_o,
  output logic                        in_range_o
);
  import rucm_pkg::*;

  localparam int QLW = QW / 2;          // low part of factor
  localparam int PXW = CW + QW;
  localparam int PYW = YMW + QW - QLW;
  localparam int SYW = YMW + QW + 1;
  localparam int IW  = RW + 1;

  logic v1_q, v2_q;
  logic xs_q, ys_q, z1_q, z2_q;
  logic [PXW-1:0] px_q;
  logic [PYW-1:0] pyh_q, pyl_q;
  logic signed [RW-1:0] rx_q, ry_q;

  logic [PXW:0] sx;
  logic [SYW-1:0] sy;
  logic [RW-2:0] rxm, rym;

  // round half away from zero on magnitudes
  assign sx  = (PXW+1)'(px_q) + ((PXW+1)'(1) << (FB-1));
  assign sy  = (SYW'(pyh_q) << QLW) + SYW'(pyl_q) + (SYW'(1) << (2*FB-1));
  assign rxm = (RW-1)'(sx[PXW:FB]);
  assign rym = (RW-1)'(sy[SYW-1:2*FB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= PXW'(side_i.ax) * PXW'(qmag_i);
      pyh_q <= PYW'(side_i.y_mag) * PYW'(qmag_i[QW-1:QLW]);
      pyl_q <= PYW'(side_i.y_mag) * PYW'(qmag_i[QLW-1:0]);
      xs_q  <= side_i.x_neg ^ qneg_i;
      ys_q  <= side_i.y_neg ^ qneg_i;
      z1_q  <= zero_i;
      rx_q  <= xs_q ? -RW'(rxm) : RW'(rxm);
      ry_q  <= ys_q ? -RW'(rym) : RW'(rym);
      z2_q  <= z1_q;
    end
  end

  logic [DIMW-1:0]       rows_c, cols_c;
  logic signed [IW-1:0]  ii, jj;

  assign rows_c = (32'(rows_i) > 32'(MAX_SOURCE_DIM)) ? DIMW'(MAX_SOURCE_DIM) : rows_i;
  assign cols_c = (32'(cols_i) > 32'(MAX_SOURCE_DIM)) ? DIMW'(MAX_SOURCE_DIM) : cols_i;
  assign ii = $signed(IW'(rows_c >> 1)) - IW'(ry_q);
  assign jj = $signed(IW'(cols_c >> 1)) + IW'(rx_q);

  assign in_range_o = !z2_q && !ii[IW-1] && (ii < $signed(IW'(rows_c)))
                   && !jj[IW-1] && (jj < $signed(IW'(cols_c)));
  assign src_row_o  = in_range_o ? ii[CW-1:0] : '0;
  assign src_col_o  = in_range_o ? jj[CW-1:0] : '0;
  assign valid_o    = v2_q;

endmodule

@@ hw/rtl/radial_undistort_coordinate_map.sv @@
// Radial undistortion coordinate map, top level.
// Stages: 3 radius, 5 polynomial, 43 divider, 2 scaling stages and the output
// register; the divider pipeline sets the depth.
// Throughput: one coordinate per cycle while the output is not stalled.
// Reset: async active low; clears pipeline valids and loads register defaults.
module radial_undistort_coordinate_map #(
  parameter int OUT_WIDTH      = rucm_pkg::OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT     = rucm_pkg::OUT_HEIGHT_DEF,
  parameter int MAX_SOURCE_DIM = rucm_pkg::MAX_SOURCE_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rucm_in_if.sink                     in_i,
  rucm_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [rucm_pkg::CFGIW-1:0]  cfg_idx_i,
  input  logic [rucm_pkg::KW-1:0]     cfg_wdata_i
);
  import rucm_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  coef_t           coef_q;
  logic [AW-1:0]   alpha_q;
  logic [DIMW-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.k1 <= KW'(64'd14002948000000);
      coef_q.k2 <= KW'(64'd23725070000);
      coef_q.k3 <= KW'(64'd19048220000000);
      coef_q.k4 <= KW'(64'd18582750000000);
      alpha_q   <= AW'(1061856250);
      rows_q    <= DIMW'(480);
      cols_q    <= DIMW'(640);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_K1:    coef_q.k1 <= cfg_wdata_i;
        CFG_K2:    coef_q.k2 <= cfg_wdata_i;
        CFG_K3:    coef_q.k3 <= cfg_wdata_i;
        CFG_K4:    coef_q.k4 <= cfg_wdata_i;
        CFG_ALPHA: alpha_q   <= cfg_wdata_i[AW-1:0];
        CFG_ROWS:  rows_q    <= cfg_wdata_i[DIMW-1:0];
        CFG_COLS:  cols_q    <= cfg_wdata_i[DIMW-1:0];
        default:   ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: one enable for all stages. The pipeline keeps moving
  // whenever its last stage is empty or the output register can take it, so a
  // parked result blocks new transfers only once the last stage is full too.
  // ---------------------------------------------------------------------
  logic en;
  logic map_valid;
  logic out_valid_q;

  assign en       = !map_valid || !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // radius: centered offsets and r^2
  logic            rad_valid;
  logic [R2W-1:0]  rad_r2;
  side_t           rad_side;

  rucm_radius #(
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT)
  ) u_radius (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_i.valid),
    .out_row_i (in_i.out_row),
    .out_col_i (in_i.out_col),
    .alpha_i   (alpha_q),
    .valid_o   (rad_valid),
    .r2_o      (rad_r2),
    .side_o    (rad_side)
  );

  // polynomial: numerator and denominator in Q30
  logic                 poly_valid;
  logic signed [NW-1:0] poly_num, poly_den;
  side_t                poly_side;

  rucm_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rad_valid),
    .r2_i    (rad_r2),
    .side_i  (rad_side),
    .coef_i  (coef_q),
    .valid_o (poly_valid),
    .num_o   (poly_num),
    .den_o   (poly_den),
    .side_o  (poly_side)
  );

  // divider: factor magnitude, sign, zero-denominator flag
  logic          div_valid;
  logic [QW-1:0] div_qmag;
  logic          div_qneg, div_zero;
  side_t         div_side;

  rucm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (poly_valid),
    .num_i   (poly_num),
    .den_i   (poly_den),
    .side_i  (poly_side),
    .valid_o (div_valid),
    .qmag_o  (div_qmag),
    .qneg_o  (div_qneg),
    .zero_o  (div_zero),
    .side_o  (div_side)
  );

  // scaling, rounding and range check
  logic [CW-1:0] map_row, map_col;
  logic          map_in;

  rucm_map #(
    .MAX_SOURCE_DIM (MAX_SOURCE_DIM)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (div_valid),
    .qmag_i     (div_qmag),
    .qneg_i     (div_qneg),
    .zero_i     (div_zero),
    .side_i     (div_side),
    .rows_i     (rows_q),
    .cols_i     (cols_q),
    .valid_o    (map_valid),
    .src_row_o  (map_row),
    .src_col_o  (map_col),
    .in_range_o (map_in)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [CW-1:0] row_q, col_q;
  logic          in_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (map_valid && en) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_valid && en) begin
      row_q      <= map_row;
      col_q      <= map_col;
      in_range_q <= map_in;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.src_row  = row_q;
  assign out_o.src_col  = col_q;
  assign out_o.in_range = in_range_q;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for radial_undistort_coordinate_map.
// Depends on rucm_pkg and the rucm_in_if / rucm_out_if channel interfaces.
// Carries its own fixed-point mapping predictor, directed and random stimulus.
module testbench;
  import rucm_pkg::*;

  localparam int OUT_W       = OUT_WIDTH_DEF;
  localparam int OUT_H       = OUT_HEIGHT_DEF;
  localparam int MAX_DIM     = MAX_SOURCE_DIM_DEF;
  localparam int DRAIN_WAIT  = 60;     // longer than the pipeline latency
  localparam int STALL_MAX   = 20000;  // cycles without any transfer before giving up
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam logic [CFGIW-1:0] CFG_UNUSED = CFGIW'(7);  // no register behind it

  typedef struct {
    logic [CW-1:0] src_row;
    logic [CW-1:0] src_col;
    logic          in_range;
  } src_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFGIW-1:0] cfg_idx_i = '0;
  logic [KW-1:0] cfg_wdata_i = '0;

  rucm_in_if  in_if ();
  rucm_out_if out_if ();

  radial_undistort_coordinate_map u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the block's registers
  logic signed [KW-1:0] num_k1, num_k2, den_k3, den_k4;
  logic [AW-1:0]        aspect;
  logic [DIMW-1:0]      rows_reg, cols_reg;

  src_point_t expected_points[$];
  bit         failed = 1'b0;
  int         send_idle_pct, recv_idle_pct;
  bit         hold_req = 1'b0;  // toggled by a test to ask for a hold-off
  bit         hold_ack = 1'b0;
  int         hold_left = 0;    // receiver hold-off, counted down by the receiver process
  int         quiet_cycles = 0;

  // |a*b| >> s, optionally rounded half away from zero, sign from a and b
  function automatic longint scaled_mul(longint a, longint b, int s, bit round_it);
    logic [63:0]  ma, mb;
    logic [127:0] p;
    logic [62:0]  m;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, ma} * {64'd0, mb};
    if (round_it) begin
      p = p + (128'd1 << (s - 1));
    end
    p = p >> s;
    m = p[62:0];
    return ((a < 0) != (b < 0)) ? -longint'({1'b0, m}) : longint'({1'b0, m});
  endfunction

  // Source pixel for one corrected pixel under the current register set.
  function automatic src_point_t map_pixel(logic [CW-1:0] row, logic [CW-1:0] col);
    src_point_t  pt;
    longint      x1, d, y1, num, den, q, rx, ry, ii, jj;
    logic [63:0] ax, ad, a2, d2, r2, r4, un, ud, qm, rows_c, cols_c;
    logic [127:0] wide;
    x1 = longint'(col) - OUT_W / 2;
    d  = OUT_H / 2 - longint'(row);
    y1 = d * longint'(aspect);
    ax = (x1 < 0) ? 64'(-x1) : 64'(x1);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    a2 = 64'(aspect) * 64'(aspect);
    d2 = ad * ad;
    // r2 in Q30: x part exact, y part floored
    r2 = ((ax * ax) << FB) + d2 * (a2 >> FB) + ((d2 * (a2 & ((64'd1 << FB) - 1))) >> FB);
    wide = {64'd0, r2} * {64'd0, r2};
    r4 = 64'(wide >> 44);  // Q16
    num = (64'sd1 <<< FB) + scaled_mul(longint'(num_k1), longint'(r2), 60, 1'b0)
                          + scaled_mul(longint'(num_k2), longint'(r4), 66, 1'b0);
    den = (64'sd1 <<< FB) + scaled_mul(longint'(den_k3), longint'(r2), 60, 1'b0)
                          + scaled_mul(longint'(den_k4), longint'(r4), 66, 1'b0);
    rows_c = (rows_reg > MAX_DIM) ? 64'(MAX_DIM) : 64'(rows_reg);
    cols_c = (cols_reg > MAX_DIM) ? 64'(MAX_DIM) : 64'(cols_reg);
    pt = '{src_row: '0, src_col: '0, in_range: 1'b0};
    if (den != 0) begin
      un = (num < 0) ? 64'(-num) : 64'(num);
      ud = (den < 0) ? 64'(-den) : 64'(den);
      qm = un / ud;
      // factor saturates at 4096.0
      if (qm >= 64'd4096) begin
        qm = 64'd4096 << FB;
      end else begin
        wide = ({64'd0, un} << FB) / {64'd0, ud};
        qm = wide[63:0];
      end
      q  = ((num < 0) != (den < 0)) ? -longint'(qm) : longint'(qm);
      rx = scaled_mul(x1, q, FB, 1'b1);
      ry = scaled_mul(y1, q, 2 * FB, 1'b1);
      ii = longint'(rows_c / 2) - ry;
      jj = longint'(cols_c / 2) + rx;
      if (ii >= 0 && ii < longint'(rows_c) && jj >= 0 && jj < longint'(cols_c)) begin
        pt.src_row  = CW'(ii);
        pt.src_col  = CW'(jj);
        pt.in_range = 1'b1;
      end
    end
    return pt;
  endfunction

  // Drive one coordinate, wait for its transfer, then idle a cycle at a time
  // with the sender's idle percentage.
  task automatic send_pixel(logic [CW-1:0] row, logic [CW-1:0] col);
    in_if.valid   <= 1'b1;
    in_if.out_row <= row;
    in_if.out_col <= col;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    expected_points.push_back(map_pixel(row, col));
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_random_pixel();
    if ($urandom_range(9) == 0) begin
      send_pixel(CW'($urandom), CW'($urandom));
    end else begin
      send_pixel(CW'($urandom_range(OUT_H - 1)), CW'($urandom_range(OUT_W - 1)));
    end
  endtask

  // Wait for every outstanding result, then let the pipe go quiet.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_points.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Writes all registers back to back, plus the unused index; only while idle.
  task automatic load_regs(logic signed [KW-1:0] k1, logic signed [KW-1:0] k2,
                           logic signed [KW-1:0] k3, logic signed [KW-1:0] k4,
                           logic [AW-1:0] alpha, logic [DIMW-1:0] rows,
                           logic [DIMW-1:0] cols);
    logic [KW-1:0] vals [7];
    vals = '{k1, k2, k3, k4, KW'(alpha), KW'(rows), KW'(cols)};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFGIW'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_UNUSED;
    cfg_wdata_i <= KW'({$urandom, $urandom});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    num_k1 = k1; num_k2 = k2; den_k3 = k3; den_k4 = k4;
    aspect = alpha; rows_reg = rows; cols_reg = cols;
    @(posedge clk_i);
  endtask

  function automatic logic signed [KW-1:0] rand_coef();
    return KW'(longint'({$urandom, $urandom}) >>> 19);  // about +-2^44
  endfunction

  // Receiver: random stalls plus the long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: each transfer against the oldest prediction.
  always @(posedge clk_i) begin
    src_point_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result: src_row %0d src_col %0d in_range %0b",
               out_if.src_row, out_if.src_col, out_if.in_range);
        failed = 1'b1;
      end else begin
        want = expected_points.pop_front();
        if (out_if.src_row !== want.src_row) begin
          $error("src_row: expected %0d, got %0d", want.src_row, out_if.src_row);
          failed = 1'b1;
        end
        if (out_if.src_col !== want.src_col) begin
          $error("src_col: expected %0d, got %0d", want.src_col, out_if.src_col);
          failed = 1'b1;
        end
        if (out_if.in_range !== want.in_range) begin
          $error("in_range: expected %0b, got %0b", want.in_range, out_if.in_range);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("radial_undistort_coordinate_map regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset values, then image corners, center, out-of-field codes.
  task automatic test_directed();
    send_pixel(CW'(0), CW'(0));
    send_pixel(CW'(0), CW'(OUT_W - 1));
    send_pixel(CW'(OUT_H - 1), CW'(0));
    send_pixel(CW'(OUT_H - 1), CW'(OUT_W - 1));
    send_pixel(CW'(OUT_H / 2), CW'(OUT_W / 2));
    send_pixel(CW'(OUT_H / 2), CW'(OUT_W / 2 + 1));
    send_pixel(CW'(OUT_H / 2 - 1), CW'(OUT_W / 2));
    send_pixel(CW'(1023), CW'(1023));
    send_pixel(CW'(1023), CW'(0));
    send_pixel(CW'(0), CW'(1023));
    drain();
  endtask

  // k3 = -2^44 and k4 = 0: the denominator hits zero at |x1| = 256 on the
  // center row and is small next to it, where the factor grows large.
  // Rows of 0 also mean nothing can land in range.
  task automatic test_zero_denominator();
    load_regs(48'sd0, 48'sd0, -(48'sd1 <<< 44), 48'sd0, AW'(1 << 30), DIMW'(0), DIMW'(640));
    send_pixel(CW'(OUT_H / 2), CW'(OUT_W / 2 + 256));
    send_pixel(CW'(OUT_H / 2), CW'(OUT_W / 2 - 256));
    drain();
    load_regs(48'sd0, 48'sd0, -(48'sd1 <<< 44), 48'sd0, AW'(1 << 30), DIMW'(480), DIMW'(640));
    send_pixel(CW'(OUT_H / 2), CW'(OUT_W / 2 + 256));
    send_pixel(CW'(OUT_H / 2), CW'(OUT_W / 2 + 255));
    send_pixel(CW'(OUT_H / 2), CW'(OUT_W / 2 + 257));
    send_pixel(CW'(OUT_H / 2), CW'(OUT_W / 2));
    drain();
  endtask

  // Random pixels across a spread of register sets, rotating the stall pattern.
  task automatic test_random_sweep();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          load_regs(48'sd14002948000000, 48'sd23725070000, 48'sd19048220000000,
                    48'sd18582750000000, AW'(1061856250), DIMW'(480), DIMW'(640));
        end
        1: begin  // identity mapping, largest in-limit source
          load_regs('0, '0, '0, '0, AW'(1 << 30), DIMW'(MAX_DIM), DIMW'(MAX_DIM));
        end
        2: begin  // largest coefficients, largest alpha, oversized source
          load_regs({1'b0, {(KW-1){1'b1}}}, {1'b0, {(KW-1){1'b1}}},
                    {1'b0, {(KW-1){1'b1}}}, {1'b0, {(KW-1){1'b1}}},
                    {AW{1'b1}}, {DIMW{1'b1}}, {DIMW{1'b1}});
        end
        3: begin  // most negative coefficients, zero alpha, one-pixel source
          load_regs({1'b1, {(KW-1){1'b0}}}, {1'b1, {(KW-1){1'b0}}},
                    {1'b1, {(KW-1){1'b0}}}, {1'b1, {(KW-1){1'b0}}},
                    '0, DIMW'(1), DIMW'(1));
        end
        default: begin
          load_regs(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                    AW'($urandom_range(32'h6000_0000, 32'h2000_0000)),
                    DIMW'($urandom_range(1, 2047)), DIMW'($urandom_range(1, 2047)));
        end
      endcase
      case (phase % 3)
        0: begin send_idle_pct = 28; recv_idle_pct = 63; end
        1: begin send_idle_pct = 63; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (200) send_random_pixel();
      drain();
    end
  endtask

  // Receiver holds off well past the pipeline depth while items keep coming.
  task automatic test_backpressure();
    load_regs(48'sd14002948000000, 48'sd23725070000, 48'sd19048220000000,
              48'sd18582750000000, AW'(1061856250), DIMW'(480), DIMW'(640));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = ~hold_req;
    repeat (150) send_random_pixel();
    drain();
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_if.valid = 1'b0;
    in_if.out_row = '0;
    in_if.out_col = '0;
    // reset values of the registers
    num_k1 = 48'sd14002948000000;
    num_k2 = 48'sd23725070000;
    den_k3 = 48'sd19048220000000;
    den_k4 = 48'sd18582750000000;
    aspect = AW'(1061856250);
    rows_reg = DIMW'(480);
    cols_reg = DIMW'(640);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_zero_denominator();
    test_random_sweep();
    test_backpressure();

    if (!failed && expected_points.size() == 0) begin
      $display("radial_undistort_coordinate_map regression: pass");
    end else begin
      if (expected_points.size() != 0) begin
        $error("%0d results never arrived", expected_points.size());
      end
      $display("radial_undistort_coordinate_map regression: fail");
    end
    $finish;
  end

endmodule

@@ radial_undistort_coordinate_map.f @@
hw/rtl/rucm_pkg.sv
hw/rtl/rucm_if.sv
hw/rtl/rucm_radius.sv
hw/rtl/rucm_poly.sv
hw/rtl/rucm_div.sv
hw/rtl/rucm_map.sv
hw/rtl/radial_undistort_coordinate_map.sv
verif/testbench.sv
